### hdl/fsa_pkg.sv
// ----------------------------------------------------------------------------
// fsa_pkg: shared definitions for the fraction sum accumulator
// Default sizes, output field widths, and the command and status groups that
// join the controller to the datapath.
// ----------------------------------------------------------------------------
package fsa_pkg;

  localparam int IN_WIDTH_DEF  = 16;
  localparam int ACC_WIDTH_DEF = 32;
  localparam int SUM_NUM_W     = 32;
  localparam int SUM_DEN_W     = 31;

  // Controller to datapath, at most one bit high per cycle.
  typedef struct packed {
    logic load_first;
    logic start;
    logic mul_step;
    logic check;
    logic gcd_step;
    logic div_step;
    logic commit;
    logic emit;
  } fsa_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic mul_done;
    logic chk_ovf;
    logic mag_zero;
    logic gcd_done;
    logic div_done;
  } fsa_status_t;

endpackage

### hdl/fsa_if.sv
// ----------------------------------------------------------------------------
// fsa_if: handshake channels of the fraction sum accumulator
// Fraction words in, reduced sum words out; a word moves when valid and
// ready are both high at a rising clock edge.
// ----------------------------------------------------------------------------
interface fsa_in_if
  import fsa_pkg::*;
#(
  parameter int IN_WIDTH = IN_WIDTH_DEF
) ();
  logic                       valid;
  logic                       ready;
  logic signed [IN_WIDTH-1:0] numerator;
  logic        [IN_WIDTH-2:0] denominator;
  logic                       first_item;
  logic                       last_item;

  modport source (output valid, numerator, denominator, first_item, last_item,
                  input ready);
  modport sink   (input valid, numerator, denominator, first_item, last_item,
                  output ready);
endinterface

interface fsa_out_if
  import fsa_pkg::*;
();
  logic                        valid;
  logic                        ready;
  logic signed [SUM_NUM_W-1:0] sum_numerator;
  logic        [SUM_DEN_W-1:0] sum_denominator;
  logic                        overflow;

  modport source (output valid, sum_numerator, sum_denominator, overflow,
                  input ready);
  modport sink   (input valid, sum_numerator, sum_denominator, overflow,
                  output ready);
endinterface

### hdl/fsa_ctrl.sv
// ----------------------------------------------------------------------------
// fsa_ctrl: sequencing controller
// Loads a word marked first; walks any other through multiply, check, gcd,
// divide and commit, and hands the sum to the output register on a last word.
// ----------------------------------------------------------------------------
module fsa_ctrl
  import fsa_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        first_item,
  input  logic        last_item,
  input  logic        out_ready,
  output logic        in_ready,
  output logic        out_valid,
  output fsa_cmd_t    cmd,
  input  fsa_status_t status
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_MUL    = 7'b0000010,
    S_CHECK  = 7'b0000100,
    S_GCD    = 7'b0001000,
    S_DIV    = 7'b0010000,
    S_COMMIT = 7'b0100000,
    S_EMIT   = 7'b1000000
  } state_t;

  state_t state, state_next;
  logic   last_q, last_q_next;
  logic   out_valid_next;
  logic   in_accept;
  logic   emit_ok;

  assign in_ready  = (state == S_IDLE);
  assign in_accept = in_valid && in_ready;
  assign emit_ok   = !out_valid || out_ready;

  always_comb begin
    state_next  = state;
    last_q_next = last_q;
    cmd         = '0;
    unique case (state)
      S_IDLE: begin
        if (in_accept) begin
          last_q_next = last_item;
          if (first_item) begin
            cmd.load_first = 1'b1;
            state_next     = last_item ? S_EMIT : S_IDLE;
          end else begin
            cmd.start  = 1'b1;
            state_next = S_MUL;
          end
        end
      end
      S_MUL: begin
        cmd.mul_step = 1'b1;
        if (status.mul_done) state_next = S_CHECK;
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        if (status.chk_ovf || status.mag_zero) begin
          state_next = last_q ? S_EMIT : S_IDLE;
        end else begin
          state_next = S_GCD;
        end
      end
      S_GCD: begin
        cmd.gcd_step = 1'b1;
        if (status.gcd_done) state_next = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_done) state_next = S_COMMIT;
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_next = last_q ? S_EMIT : S_IDLE;
      end
      S_EMIT: begin
        if (emit_ok) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.emit) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      last_q    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      last_q    <= last_q_next;
      out_valid <= out_valid_next;
    end
  end

`ifndef SYNTHESIS
  a_start_mul: assert property (@(posedge clk) disable iff (rst)
    (in_accept && !first_item) |=> (state == S_MUL))
    else $error("non-first word did not start the multiply");

  a_rose_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_EMIT))
    else $error("sum word appeared outside the emit step");

  a_check_exit: assert property (@(posedge clk) disable iff (rst)
    (state == S_CHECK) |=> (state == S_GCD || state == S_IDLE || state == S_EMIT))
    else $error("bad exit from the check step");
`endif

endmodule

### hdl/fsa_dp.sv
// ----------------------------------------------------------------------------
// fsa_dp: accumulator datapath
// Shift-add cross products, sign combine and range check, binary gcd, and a
// restoring divider that reduces numerator and denominator side by side.
// ----------------------------------------------------------------------------
module fsa_dp
  import fsa_pkg::*;
#(
  parameter int IN_WIDTH  = IN_WIDTH_DEF,
  parameter int ACC_WIDTH = ACC_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  fsa_cmd_t                    cmd,
  output fsa_status_t                 status,
  input  logic signed [IN_WIDTH-1:0]  numerator,
  input  logic        [IN_WIDTH-2:0]  denominator,
  output logic signed [SUM_NUM_W-1:0] sum_numerator,
  output logic        [SUM_DEN_W-1:0] sum_denominator,
  output logic                        overflow
);

  localparam int DW  = IN_WIDTH - 1;
  localparam int DNW = (ACC_WIDTH > DW) ? ACC_WIDTH : DW;
  localparam int PW  = ACC_WIDTH + IN_WIDTH;
  localparam int SW  = (PW + 1 > 65) ? PW + 1 : 65;
  localparam int GW  = (PW + 1 < 64) ? PW + 1 : 64;
  localparam int CW  = $clog2((IN_WIDTH > GW) ? IN_WIDTH : GW);
  localparam int KW  = $clog2(GW);
  localparam logic [GW-1:0] HALF = {{(GW-1){1'b0}}, 1'b1} << (ACC_WIDTH - 1);

  // Accumulator state
  logic [ACC_WIDTH-1:0] acc_num;
  logic [DNW-1:0]       acc_den;
  logic                 ovf_flag;

  // Multiply stage
  logic [SW-1:0]       am_sh, b_sh, p, q, bd;
  logic [DW-1:0]       d_sh;
  logic [IN_WIDTH-1:0] cm_sh;
  logic                aneg, cneg;

  // Gcd and divide
  logic [GW-1:0] u, v, g, xn, xd;
  logic [KW-1:0] k;
  logic          neg;
  logic [GW:0]   rn, rd;
  logic [CW-1:0] cnt;

  logic [SUM_NUM_W-1:0] out_num;
  logic [SUM_DEN_W-1:0] out_den;
  logic                 out_ovf;

  // Input decode
  logic [IN_WIDTH-1:0]  nraw, cm_in;
  logic                 cneg_in;
  logic [DW-1:0]        d_fix;
  logic [ACC_WIDTH-1:0] am_c, b_c;

  always_comb begin
    nraw    = numerator;
    cneg_in = nraw[IN_WIDTH-1];
    cm_in   = cneg_in ? (IN_WIDTH'(0) - nraw) : nraw;
    d_fix   = (denominator == '0) ? DW'(1) : denominator;
    am_c    = acc_num[ACC_WIDTH-1] ? (ACC_WIDTH'(0) - acc_num) : acc_num;
    b_c     = ACC_WIDTH'(acc_den);
  end

  // Sign combine and range check on the raw products
  logic [SW-1:0] s_sum, mag_full;
  logic          same, p_ge_q, neg_c;
  logic [GW-1:0] mag_g, bd_g;

  always_comb begin
    same     = (aneg == cneg);
    p_ge_q   = (p >= q);
    s_sum    = p + q;
    if (same) begin
      mag_full = s_sum;
    end else if (p_ge_q) begin
      mag_full = p - q;
    end else begin
      mag_full = q - p;
    end
    neg_c  = (same || p_ge_q) ? aneg : cneg;
    mag_g  = GW'(mag_full);
    bd_g   = GW'(bd);
    status.mul_done = (cnt == CW'(IN_WIDTH - 1));
    status.div_done = (cnt == CW'(GW - 1));
    // a denominator truncated to zero by the accumulator width never reduces
    status.chk_ovf  = (p[SW-1:64] != '0) || (q[SW-1:64] != '0) ||
                      (bd[SW-1:64] != '0) || (same && (s_sum[SW-1:64] != '0)) ||
                      (bd == '0);
    status.mag_zero = (mag_full == '0);
    status.gcd_done = u[0] && v[0] && (u == v);
  end

  // Divider step, both dividends against the shared divisor
  logic [GW:0] rn_sh, rd_sh;
  logic        ge_n, ge_d;

  always_comb begin
    rn_sh = {rn[GW-1:0], xn[GW-1]};
    rd_sh = {rd[GW-1:0], xd[GW-1]};
    ge_n  = (rn_sh >= {1'b0, g});
    ge_d  = (rd_sh >= {1'b0, g});
  end

  // Commit check on the reduced pair
  logic [GW-1:0] lim_n;
  logic          c_ovf;

  always_comb begin
    lim_n = neg ? HALF : (HALF - GW'(1));
    c_ovf = (xn > lim_n) || (xd > (HALF - GW'(1))) || (xd == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_num  <= '0;
      acc_den  <= DNW'(1);
      ovf_flag <= 1'b0;
    end else if (cmd.load_first) begin
      acc_num  <= ACC_WIDTH'(numerator);
      acc_den  <= DNW'(d_fix);
      ovf_flag <= 1'b0;
    end else if (cmd.check) begin
      if (status.chk_ovf) begin
        ovf_flag <= 1'b1;
      end else if (status.mag_zero) begin
        acc_num <= '0;
        acc_den <= DNW'(1);
      end
    end else if (cmd.commit) begin
      if (c_ovf) begin
        ovf_flag <= 1'b1;
      end else begin
        acc_num <= ACC_WIDTH'(neg ? (GW'(0) - xn) : xn);
        acc_den <= DNW'(xd);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      am_sh <= SW'(am_c);
      b_sh  <= SW'(b_c);
      d_sh  <= d_fix;
      cm_sh <= cm_in;
      aneg  <= acc_num[ACC_WIDTH-1];
      cneg  <= cneg_in;
      p     <= '0;
      q     <= '0;
      bd    <= '0;
      cnt   <= '0;
    end
    if (cmd.mul_step) begin
      if (d_sh[0]) begin
        p  <= p + am_sh;
        bd <= bd + b_sh;
      end
      if (cm_sh[0]) q <= q + b_sh;
      am_sh <= am_sh << 1;
      b_sh  <= b_sh << 1;
      d_sh  <= d_sh >> 1;
      cm_sh <= cm_sh >> 1;
      cnt   <= cnt + CW'(1);
    end
    if (cmd.check) begin
      u   <= mag_g;
      v   <= bd_g;
      xn  <= mag_g;
      xd  <= bd_g;
      k   <= '0;
      neg <= neg_c && !status.mag_zero;
    end
    if (cmd.gcd_step) begin
      if (status.gcd_done) begin
        g   <= u << k;
        rn  <= '0;
        rd  <= '0;
        cnt <= '0;
      end else if (!u[0] && !v[0]) begin
        u <= u >> 1;
        v <= v >> 1;
        k <= k + KW'(1);
      end else if (!u[0]) begin
        u <= u >> 1;
      end else if (!v[0]) begin
        v <= v >> 1;
      end else if (u > v) begin
        u <= u - v;
      end else begin
        v <= v - u;
      end
    end
    if (cmd.div_step) begin
      rn  <= ge_n ? (rn_sh - {1'b0, g}) : rn_sh;
      rd  <= ge_d ? (rd_sh - {1'b0, g}) : rd_sh;
      xn  <= {xn[GW-2:0], ge_n};
      xd  <= {xd[GW-2:0], ge_d};
      cnt <= cnt + CW'(1);
    end
    if (cmd.emit) begin
      out_num <= SUM_NUM_W'(acc_num);
      out_den <= SUM_DEN_W'(acc_den);
      out_ovf <= ovf_flag;
    end
  end

  assign sum_numerator   = out_num;
  assign sum_denominator = out_den;
  assign overflow        = out_ovf;

`ifndef SYNTHESIS
  a_den_nonzero: assert property (@(posedge clk) disable iff (rst)
    acc_den != '0)
    else $error("accumulated denominator is zero");

  a_gcd_operands: assert property (@(posedge clk) disable iff (rst)
    cmd.gcd_step |-> (u != '0 && v != '0))
    else $error("gcd operand reached zero");

  a_div_remainder: assert property (@(posedge clk) disable iff (rst)
    cmd.div_step |-> (rn < {1'b0, g} && rd < {1'b0, g}))
    else $error("divider remainder not below divisor");
`endif

endmodule

### hdl/fraction_sum_accumulator.sv
// ----------------------------------------------------------------------------
// fraction_sum_accumulator: running sum of fractions with gcd reduction
// Adds signed fractions by cross multiplication, reduces each partial sum
// by the gcd of numerator and denominator, and returns the sum after a word marked last.
// ----------------------------------------------------------------------------
//
//   channel   dir   word                                          accepted
//   fraction  in    numerator, denominator, first_item, last_item  valid & ready
//   sum       out   sum_numerator, sum_denominator, overflow       valid & ready
//
// A word marked first loads directly. Any other word runs through accept, IN_WIDTH
// shift-add steps, check, binary gcd steps plus one to latch the divisor,
// GW = min(ACC_WIDTH + IN_WIDTH + 1, 64) divide steps and commit; an overflowed
// or zero sum stops after the check. A word marked last then loads the output
// register in the emit step. Reset is synchronous and leaves the sum at 0/1
// with overflow clear. A stalled sum word holds in the output register while
// the next fraction is taken; the block waits only when a new sum finds that
// register full.
// ----------------------------------------------------------------------------
module fraction_sum_accumulator
  import fsa_pkg::*;
#(
  parameter int IN_WIDTH  = IN_WIDTH_DEF,
  parameter int ACC_WIDTH = ACC_WIDTH_DEF
) (
  input logic       clk,
  input logic       rst,
  fsa_in_if.sink    fraction,
  fsa_out_if.source sum
);

  fsa_cmd_t    cmd;
  fsa_status_t status;

  // Sequencer: owns the handshakes and steps the datapath
  fsa_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (fraction.valid),
    .first_item (fraction.first_item),
    .last_item  (fraction.last_item),
    .out_ready  (sum.ready),
    .in_ready   (fraction.ready),
    .out_valid  (sum.valid),
    .cmd        (cmd),
    .status     (status)
  );

  // Datapath: accumulator, products, gcd, divider and output register
  fsa_dp #(
    .IN_WIDTH  (IN_WIDTH),
    .ACC_WIDTH (ACC_WIDTH)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .numerator       (fraction.numerator),
    .denominator     (fraction.denominator),
    .sum_numerator   (sum.sum_numerator),
    .sum_denominator (sum.sum_denominator),
    .overflow        (sum.overflow)
  );

endmodule
